### hdl/slth_pkg.sv
// Package for the script lexer with token hash: token kinds, lexer modes,
// payload structs, character codes and the hash mix/fold helpers.
// No dependencies.
package slth_pkg;

  // Longest kept text of a string, symbol or section
  localparam int MAX_TEXT = 4096;
  localparam int TEXT_W   = 13;
  localparam int CNT_W    = $clog2(MAX_TEXT + 1);
  localparam int LINE_W   = 16;
  localparam int HASH_W   = 32;
  localparam int THASH_W  = 16;
  localparam int NUM_W    = 32;

  // Result queue
  localparam int QDEPTH  = 4;
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_SPACE_END = 8'd33;  // codes below this are blank
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS  = 8'd32;

  typedef enum logic [3:0] {
    KIND_EOF     = 4'd0,
    KIND_OPEN    = 4'd1,
    KIND_CLOSE   = 4'd2,
    KIND_COMMA   = 4'd3,
    KIND_NUMBER  = 4'd4,
    KIND_STRING  = 4'd5,
    KIND_SYMBOL  = 4'd6,
    KIND_SECTION = 4'd7,
    KIND_BAD     = 4'd8
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NUM  = 3'd1,
    MODE_SYM  = 3'd2,
    MODE_SEC  = 3'd3,
    MODE_STR  = 3'd4,
    MODE_ESC  = 3'd5
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } slth_in_t;

  typedef struct packed {
    tok_kind_t                 kind;
    logic signed [NUM_W-1:0]   number_value;
    logic [THASH_W-1:0]        text_hash;
    logic [TEXT_W-1:0]         text_length;
    logic [LINE_W-1:0]         line_number;
    logic                      last;
  } slth_out_t;

  // Token before the hash fold
  typedef struct packed {
    tok_kind_t          kind;
    logic [NUM_W-1:0]   value;
    logic [HASH_W-1:0]  hash;
    logic [TEXT_W-1:0]  len;
    logic [LINE_W-1:0]  line;
    logic               last;
  } slth_raw_t;

  function automatic logic [HASH_W-1:0] mix_char(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] c);
    logic [HASH_W-1:0] t;
    t = h + {{(HASH_W-8){1'b0}}, c};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [THASH_W-1:0] fold_hash(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t[THASH_W-1:0] ^ t[HASH_W-1:THASH_W];
  endfunction

  function automatic slth_out_t to_out(input slth_raw_t r);
    slth_out_t o;
    o.kind         = r.kind;
    o.number_value = r.value;
    o.text_hash    = fold_hash(r.hash);
    o.text_length  = r.len;
    o.line_number  = r.line;
    o.last         = r.last;
    return o;
  endfunction

endpackage

### hdl/script_lexer_with_token_hash_core.sv
// Script lexer top level: byte-in, token-out lexer with folded text hash.
// Depends on slth_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one source byte per beat,
//   or an end-of-file marker (in_data.end_of_file = 1, byte ignored).
//   Output channel (out_valid/out_ready/out_data) gives one token per beat;
//   out_data.last marks the final token caused by an input beat. A beat may
//   cause zero, one or two tokens.
//   The tokens of a byte are registered in the lexer stage, then hash-folded
//   into the result queue, from which out_data is read.
//   Throughput: one byte per cycle while each byte yields at most one token
//   and out_ready stays high; a byte that yields two tokens costs two output
//   beats. in_ready is set by the result queue fill plus the tokens in
//   flight, and drops when fewer than two free queue slots are assured.
//   Reset (rst_n low, synchronous) returns the lexer to between tokens,
//   line counter to 1, and empties the queue.
//   When the receiver stalls, tokens wait in a 4-entry queue and input
//   is held off once the queue cannot absorb another two tokens.
module script_lexer_with_token_hash_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slth_pkg::slth_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output slth_pkg::slth_out_t out_data
);

  // Lexer state
  slth_pkg::lex_mode_t              mode_r, mode_nxt;
  logic [slth_pkg::HASH_W-1:0]      hash_r, hash_nxt;
  logic [slth_pkg::NUM_W-1:0]       num_r, num_nxt;
  logic                             neg_r, neg_nxt;
  logic [slth_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [slth_pkg::LINE_W-1:0]      line_r, line_nxt;

  // Stage 1 result registers
  logic                             s1_vld_r;
  logic [1:0]                       s1_n_r;
  slth_pkg::slth_raw_t              s1_res0_r, s1_res1_r;

  // Result queue
  slth_pkg::slth_out_t              q_mem [slth_pkg::QDEPTH];
  logic [slth_pkg::QIDX_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [slth_pkg::QCNT_W-1:0]      qcnt_r, qcnt_nxt;

  logic                             in_fire, out_fire;
  logic [7:0]                       c;
  logic                             is_eof;
  logic                             c_digit, c_alpha, c_symch;
  logic [3:0]                       c_dval;

  // Candidate tokens: finish of current token, eof or single-char token,
  // and text-limit flush
  slth_pkg::slth_raw_t              tok_a, tok_b, tok_c;
  logic                             a_v, b_v, c_v;
  logic                             idle_go, text_go;
  logic [7:0]                       text_chr, text_lc;
  logic [slth_pkg::HASH_W-1:0]      text_hash;
  logic [slth_pkg::CNT_W-1:0]       text_cnt;
  slth_pkg::slth_raw_t              res0, res1;
  logic [1:0]                       res_n;
  logic [2:0]                       in_flight;
  logic [slth_pkg::QCNT_W:0]        pend;

  assign c       = in_data.in_byte;
  assign is_eof  = in_data.end_of_file;
  assign in_fire = in_valid && in_ready;

  assign c_digit = c inside {[slth_pkg::CH_0:slth_pkg::CH_9]};
  assign c_alpha = (c inside {[slth_pkg::CH_UP_A:slth_pkg::CH_UP_Z]}) ||
                   (c inside {[slth_pkg::CH_LOW_A:slth_pkg::CH_LOW_Z]});
  assign c_symch = c_alpha || c_digit || (c == slth_pkg::CH_UNDER);
  assign c_dval  = 4'(c - slth_pkg::CH_0);

  // Token that the current mode would emit if it ended now
  always_comb begin
    tok_a       = '0;
    tok_a.line  = line_r;
    tok_a.kind  = slth_pkg::KIND_STRING;
    case (mode_r)
      slth_pkg::MODE_NUM: begin
        tok_a.kind  = slth_pkg::KIND_NUMBER;
        tok_a.value = neg_r ? (slth_pkg::NUM_W'(0) - num_r) : num_r;
      end
      slth_pkg::MODE_SYM: tok_a.kind = slth_pkg::KIND_SYMBOL;
      slth_pkg::MODE_SEC: tok_a.kind = slth_pkg::KIND_SECTION;
      default:            tok_a.kind = slth_pkg::KIND_STRING;
    endcase
    if (mode_r != slth_pkg::MODE_NUM) begin
      tok_a.hash = hash_r;
      tok_a.len  = slth_pkg::TEXT_W'(cnt_r);
    end
  end

  // Lexer next state
  always_comb begin
    mode_nxt  = mode_r;
    hash_nxt  = hash_r;
    num_nxt   = num_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    line_nxt  = line_r;
    a_v       = 1'b0;
    b_v       = 1'b0;
    c_v       = 1'b0;
    idle_go   = 1'b0;
    text_go   = 1'b0;
    text_chr  = c;
    text_lc   = c;
    text_hash = '0;
    text_cnt  = '0;
    tok_b      = '0;
    tok_b.line = line_r;
    tok_c      = '0;
    tok_c.line = line_r;

    if (is_eof) begin
      a_v        = (mode_r != slth_pkg::MODE_IDLE);
      b_v        = 1'b1;
      tok_b.kind = slth_pkg::KIND_EOF;
      mode_nxt   = slth_pkg::MODE_IDLE;
      hash_nxt   = '0;
      num_nxt    = '0;
      neg_nxt    = 1'b0;
      cnt_nxt    = '0;
    end else begin
      case (mode_r)
        slth_pkg::MODE_NUM: begin
          if (c_digit) begin
            num_nxt = (num_r << 3) + (num_r << 1) +
                      {{(slth_pkg::NUM_W-4){1'b0}}, c_dval};
          end else begin
            a_v     = 1'b1;
            idle_go = 1'b1;
          end
        end
        slth_pkg::MODE_SYM, slth_pkg::MODE_SEC: begin
          if (c_symch) begin
            text_go = 1'b1;
          end else begin
            a_v     = 1'b1;
            idle_go = 1'b1;
          end
        end
        slth_pkg::MODE_STR: begin
          if (c == slth_pkg::CH_QUOTE) begin
            a_v      = 1'b1;
            mode_nxt = slth_pkg::MODE_IDLE;
            hash_nxt = '0;
            cnt_nxt  = '0;
          end else if (c == slth_pkg::CH_BSLASH) begin
            mode_nxt = slth_pkg::MODE_ESC;
          end else begin
            text_go = 1'b1;
          end
        end
        slth_pkg::MODE_ESC: begin
          mode_nxt = slth_pkg::MODE_STR;
          if ((c == slth_pkg::CH_BSLASH) || (c == slth_pkg::CH_QUOTE)) begin
            text_go = 1'b1;
          end else if (c == slth_pkg::CH_LOW_N) begin
            text_go  = 1'b1;
            text_chr = slth_pkg::CH_NL;
          end
        end
        default: idle_go = 1'b1;
      endcase

      // Byte seen between tokens (also the byte that ended a number, symbol or section)
      if (idle_go) begin
        mode_nxt = slth_pkg::MODE_IDLE;
        hash_nxt = '0;
        num_nxt  = '0;
        neg_nxt  = 1'b0;
        cnt_nxt  = '0;
        if (c < slth_pkg::CH_SPACE_END) begin
          if (c == slth_pkg::CH_NL) begin
            line_nxt = line_r + slth_pkg::LINE_W'(1);
          end
        end else if (c == slth_pkg::CH_LPAREN) begin
          b_v        = 1'b1;
          tok_b.kind = slth_pkg::KIND_OPEN;
        end else if (c == slth_pkg::CH_RPAREN) begin
          b_v        = 1'b1;
          tok_b.kind = slth_pkg::KIND_CLOSE;
        end else if (c == slth_pkg::CH_COMMA) begin
          b_v        = 1'b1;
          tok_b.kind = slth_pkg::KIND_COMMA;
        end else if (c == slth_pkg::CH_COLON) begin
          mode_nxt = slth_pkg::MODE_SEC;
        end else if (c_alpha || (c == slth_pkg::CH_UNDER)) begin
          mode_nxt = slth_pkg::MODE_SYM;
          text_go  = 1'b1;
        end else if (c == slth_pkg::CH_MINUS) begin
          mode_nxt = slth_pkg::MODE_NUM;
          neg_nxt  = 1'b1;
        end else if (c == slth_pkg::CH_PLUS) begin
          mode_nxt = slth_pkg::MODE_NUM;
        end else if (c_digit) begin
          mode_nxt = slth_pkg::MODE_NUM;
          num_nxt  = {{(slth_pkg::NUM_W-4){1'b0}}, c_dval};
        end else if (c == slth_pkg::CH_QUOTE) begin
          mode_nxt = slth_pkg::MODE_STR;
        end else begin
          b_v        = 1'b1;
          tok_b.kind = slth_pkg::KIND_BAD;
        end
      end

      // Keep one text character, lower-cased for the hash; flush when the text is full
      if (text_go) begin
        text_lc   = (text_chr inside {[slth_pkg::CH_UP_A:slth_pkg::CH_UP_Z]}) ?
                    (text_chr + slth_pkg::CASE_OFS) : text_chr;
        text_hash = slth_pkg::mix_char(hash_nxt, text_lc);
        text_cnt  = cnt_nxt + slth_pkg::CNT_W'(1);
        hash_nxt  = text_hash;
        cnt_nxt   = text_cnt;
        if (text_cnt >= slth_pkg::CNT_W'(slth_pkg::MAX_TEXT)) begin
          c_v       = 1'b1;
          tok_c.hash = text_hash;
          tok_c.len  = slth_pkg::TEXT_W'(text_cnt);
          case (mode_nxt)
            slth_pkg::MODE_SYM: tok_c.kind = slth_pkg::KIND_SYMBOL;
            slth_pkg::MODE_SEC: tok_c.kind = slth_pkg::KIND_SECTION;
            default:            tok_c.kind = slth_pkg::KIND_STRING;
          endcase
          mode_nxt = slth_pkg::MODE_IDLE;
          hash_nxt = '0;
          cnt_nxt  = '0;
        end
      end
    end
  end

  // Pack up to two tokens in order, mark the final one
  always_comb begin
    res_n = 2'(a_v) + 2'(b_v) + 2'(c_v);
    res0  = a_v ? tok_a : (b_v ? tok_b : tok_c);
    res1  = a_v ? (b_v ? tok_b : tok_c) : tok_c;
    res0.last = (res_n == 2'd1);
    res1.last = (res_n == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= slth_pkg::MODE_IDLE;
      hash_r   <= '0;
      num_r    <= '0;
      neg_r    <= 1'b0;
      cnt_r    <= '0;
      line_r   <= slth_pkg::LINE_W'(1);
      s1_vld_r <= 1'b0;
      s1_n_r   <= '0;
    end else begin
      s1_vld_r <= in_fire;
      if (in_fire) begin
        mode_r <= mode_nxt;
        hash_r <= hash_nxt;
        num_r  <= num_nxt;
        neg_r  <= neg_nxt;
        cnt_r  <= cnt_nxt;
        line_r <= line_nxt;
        s1_n_r <= res_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res0_r <= res0;
      s1_res1_r <= res1;
    end
  end

  // Fold stage into result queue
  assign in_flight = s1_vld_r ? {1'b0, s1_n_r} : 3'd0;
  assign pend      = {1'b0, qcnt_r} + (slth_pkg::QCNT_W + 1)'(in_flight);
  assign in_ready  = (pend <= (slth_pkg::QCNT_W + 1)'(slth_pkg::QDEPTH - 2));

  assign out_valid = (qcnt_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = q_mem[rd_ptr_r];

  assign qcnt_nxt = qcnt_r + slth_pkg::QCNT_W'(in_flight) -
                    slth_pkg::QCNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (s1_vld_r && (s1_n_r != 2'd0)) begin
      q_mem[wr_ptr_r] <= slth_pkg::to_out(s1_res0_r);
    end
    if (s1_vld_r && (s1_n_r == 2'd2)) begin
      q_mem[wr_ptr_r + slth_pkg::QIDX_W'(1)] <= slth_pkg::to_out(s1_res1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      qcnt_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + slth_pkg::QIDX_W'(in_flight);
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + slth_pkg::QIDX_W'(1);
      end
      qcnt_r <= qcnt_nxt;
    end
  end

  // Checks
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= slth_pkg::QCNT_W'(slth_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_s1_follow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_vld_r)
    else $error("accepted beat missing from lexer stage");

  a_last_two: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && (s1_n_r == 2'd2)) |-> (!s1_res0_r.last && s1_res1_r.last))
    else $error("last flag wrong on two-token beat");

  a_last_one: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && (s1_n_r == 2'd1)) |-> s1_res0_r.last)
    else $error("last flag missing on single-token beat");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == slth_pkg::MODE_IDLE) |-> ((cnt_r == '0) && (hash_r == '0)))
    else $error("text state left over between tokens");

endmodule
